FILE: hdl/vfc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the voxel face-culling mesher.
// No dependencies; used by every module of the block.
package vfc_pkg;

    localparam logic [2:0] CLS_SOLID  = 3'd0;
    localparam logic [2:0] CLS_LEAVES = 3'd1;
    localparam logic [2:0] CLS_TRANSP = 3'd2;
    localparam logic [2:0] CLS_BILL   = 3'd3;
    localparam logic [2:0] CLS_LIQUID = 3'd4;

    localparam logic [1:0] MESH_MAIN  = 2'd0;
    localparam logic [1:0] MESH_WATER = 2'd1;
    localparam logic [1:0] MESH_BILL  = 2'd2;

    localparam logic [2:0] DIR_BOTTOM = 3'd4;
    localparam logic [2:0] DIR_TOP    = 3'd5;

    localparam int NSLOT     = 7;
    localparam int SLOT_BACK = 6;
    localparam int CNT_W     = 17;
    localparam logic [CNT_W-1:0] QUAD_VERTS = 17'd4;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [3:0]  vox_x;
        logic [3:0]  vox_y;
        logic [3:0]  vox_z;
        logic [15:0] block_id;
        logic [2:0]  self_class;
        logic [2:0]  north_class;
        logic [2:0]  south_class;
        logic [2:0]  west_class;
        logic [2:0]  east_class;
        logic [2:0]  below_class;
        logic [2:0]  above_class;
        logic        chunk_start;
    } t_vox_in;

    typedef struct packed {
        logic [1:0]       mesh_sel;
        logic [2:0]       face_dir;
        logic [3:0]       face_x;
        logic [3:0]       face_y;
        logic [3:0]       face_z;
        logic [15:0]      face_block;
        logic [CNT_W-1:0] base_vertex;
        logic             top_flag;
        logic             back_side;
        logic             last_face;
    } t_face_out;

    // Slots 0..4 are north..bottom, slot 5 the top face, slot 6 the back copy
    // of a liquid top. A billboard uses slots 0 and 1 for its two planes.
    typedef struct packed {
        logic [3:0]       x;
        logic [3:0]       y;
        logic [3:0]       z;
        logic [15:0]      block;
        logic [1:0]       mesh;
        logic [NSLOT-1:0] mask;
        logic             side_top;
        logic             chunk_start;
    } t_job;

    function automatic logic [2:0] norm_class(input logic [2:0] c);
        return (c > CLS_LIQUID) ? CLS_SOLID : c;
    endfunction

    function automatic logic see_through(input logic [2:0] c);
        return (c == CLS_LEAVES) || (c == CLS_TRANSP) || (c == CLS_BILL);
    endfunction

endpackage

FILE: hdl/vfc_front.sv
`timescale 1ns / 1ps
// Front part: accepts voxels and turns each into a job with a visible-face mask.
// Depends on vfc_pkg.
module vfc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  vfc_pkg::t_vox_in i_in,
    input  logic           i_full,
    output logic           o_push,
    output vfc_pkg::t_job  o_job
);

    logic [2:0] self_c;
    logic [2:0] above_c;
    logic [2:0] nb [0:4];
    logic       liquid;
    logic [vfc_pkg::NSLOT-1:0] mask;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        self_c  = vfc_pkg::norm_class(i_in.self_class);
        above_c = vfc_pkg::norm_class(i_in.above_class);
        nb[0]   = vfc_pkg::norm_class(i_in.north_class);
        nb[1]   = vfc_pkg::norm_class(i_in.south_class);
        nb[2]   = vfc_pkg::norm_class(i_in.west_class);
        nb[3]   = vfc_pkg::norm_class(i_in.east_class);
        nb[4]   = vfc_pkg::norm_class(i_in.below_class);
        liquid  = (self_c == vfc_pkg::CLS_LIQUID);
        mask    = '0;
        if (self_c == vfc_pkg::CLS_BILL) begin
            mask[0] = 1'b1;
            mask[1] = 1'b1;
        end else begin
            for (int d = 0; d < 5; d++) begin
                mask[d] = vfc_pkg::see_through(nb[d])
                          || ((nb[d] == vfc_pkg::CLS_LIQUID) && !liquid);
            end
            if (liquid) begin
                mask[5] = (above_c != vfc_pkg::CLS_LIQUID);
                mask[6] = (above_c != vfc_pkg::CLS_LIQUID);
            end else begin
                mask[5] = vfc_pkg::see_through(above_c) || (above_c == vfc_pkg::CLS_LIQUID);
            end
        end
        if (i_in.block_id == 16'd0) begin
            mask = '0;
        end

        o_job.x           = i_in.vox_x;
        o_job.y           = i_in.vox_y;
        o_job.z           = i_in.vox_z;
        o_job.block       = i_in.block_id;
        o_job.mesh        = (self_c == vfc_pkg::CLS_BILL) ? vfc_pkg::MESH_BILL
                          : liquid ? vfc_pkg::MESH_WATER : vfc_pkg::MESH_MAIN;
        o_job.mask        = mask;
        o_job.side_top    = liquid && (above_c == vfc_pkg::CLS_TRANSP);
        o_job.chunk_start = i_in.chunk_start;
    end

    // Empty voxels are still pushed so that their chunk start reaches the counters.
    ast_empty_no_faces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && (i_in.block_id == 16'd0)) |-> (o_job.mask == '0))
        else $error("empty voxel produced faces");

    ast_bill_two_planes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && (o_job.mesh == vfc_pkg::MESH_BILL)) |-> (o_job.mask[6:2] == '0))
        else $error("billboard job with non-plane faces");

    ast_top_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.mask[6]) |-> (o_job.mask[5] && (o_job.mesh == vfc_pkg::MESH_WATER)))
        else $error("back top face without front top face");

endmodule

FILE: hdl/vfc_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front and back parts.
// Depends on vfc_pkg.
module vfc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vfc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output vfc_pkg::t_job o_head
);

    vfc_pkg::t_job            r_mem [0:vfc_pkg::QDEPTH-1];
    logic [vfc_pkg::QAW-1:0]  r_wr;
    logic [vfc_pkg::QAW-1:0]  r_rd;
    logic [vfc_pkg::QAW:0]    r_count;
    logic [vfc_pkg::QAW:0]    n_count;
    logic                     do_pop;

    assign o_full  = (r_count == (vfc_pkg::QAW+1)'(vfc_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    ast_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

    ast_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (vfc_pkg::QAW+1)'(vfc_pkg::QDEPTH))
        else $error("queue count out of range");

    ast_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == r_count[vfc_pkg::QAW-1:0])
        else $error("queue pointers disagree with count");

endmodule

FILE: hdl/vfc_back.sv
`timescale 1ns / 1ps
// Back part: walks the face mask of the queue head, one face per cycle while the
// output is not stalled, and keeps the three vertex counters. Depends on vfc_pkg.
module vfc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  vfc_pkg::t_job      i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vfc_pkg::t_face_out o_out
);

    logic [vfc_pkg::NSLOT-1:0] r_done;
    logic [vfc_pkg::NSLOT-1:0] rem;
    logic [vfc_pkg::NSLOT-1:0] onehot;
    logic [2:0]                slot;
    logic                      step;
    logic                      emit;
    logic                      is_last;
    logic                      clr;
    logic [vfc_pkg::CNT_W-1:0] r_main_cnt, r_water_cnt, r_bill_cnt;
    logic [vfc_pkg::CNT_W-1:0] n_main_cnt, n_water_cnt, n_bill_cnt;
    logic [vfc_pkg::CNT_W-1:0] base;
    logic                      r_out_valid;
    vfc_pkg::t_face_out        r_out;
    vfc_pkg::t_face_out        n_out;

    assign rem     = i_head.mask & ~r_done;
    assign onehot  = rem & (~rem + 1'b1);
    assign is_last = ((rem & ~onehot) == '0);
    assign step    = i_head_valid && (!r_out_valid || i_out_ready);
    assign emit    = step && (rem != '0);
    assign o_pop   = step && is_last;
    assign clr     = i_head.chunk_start && (r_done == '0);

    always_comb begin
        slot = 3'd0;
        for (int i = 0; i < vfc_pkg::NSLOT; i++) begin
            if (onehot[i]) begin
                slot = 3'(i);
            end
        end
    end

    always_comb begin
        n_main_cnt  = clr ? '0 : r_main_cnt;
        n_water_cnt = clr ? '0 : r_water_cnt;
        n_bill_cnt  = clr ? '0 : r_bill_cnt;
        unique case (i_head.mesh)
            vfc_pkg::MESH_WATER: begin
                base        = n_water_cnt;
                n_water_cnt = n_water_cnt + vfc_pkg::QUAD_VERTS;
            end
            vfc_pkg::MESH_BILL: begin
                base       = n_bill_cnt;
                n_bill_cnt = n_bill_cnt + vfc_pkg::QUAD_VERTS;
            end
            default: begin
                base       = n_main_cnt;
                n_main_cnt = n_main_cnt + vfc_pkg::QUAD_VERTS;
            end
        endcase
        if (rem == '0) begin
            n_main_cnt  = clr ? '0 : r_main_cnt;
            n_water_cnt = clr ? '0 : r_water_cnt;
            n_bill_cnt  = clr ? '0 : r_bill_cnt;
        end
    end

    always_comb begin
        n_out.mesh_sel    = i_head.mesh;
        n_out.face_dir    = (slot >= vfc_pkg::DIR_TOP) ? vfc_pkg::DIR_TOP : slot;
        n_out.face_x      = i_head.x;
        n_out.face_y      = i_head.y;
        n_out.face_z      = i_head.z;
        n_out.face_block  = i_head.block;
        n_out.base_vertex = base;
        n_out.top_flag    = (i_head.mesh == vfc_pkg::MESH_WATER)
                            && ((slot >= vfc_pkg::DIR_TOP)
                                || ((slot < vfc_pkg::DIR_BOTTOM) && i_head.side_top));
        n_out.back_side   = (slot == 3'(vfc_pkg::SLOT_BACK));
        n_out.last_face   = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
            r_main_cnt  <= '0;
            r_water_cnt <= '0;
            r_bill_cnt  <= '0;
        end else begin
            if (step) begin
                r_done      <= o_pop ? '0 : (r_done | onehot);
                r_main_cnt  <= n_main_cnt;
                r_water_cnt <= n_water_cnt;
                r_bill_cnt  <= n_bill_cnt;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    ast_base_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.base_vertex[1:0] == 2'b00))
        else $error("base vertex not quad aligned");

    ast_back_is_water_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.back_side)
        |-> ((r_out.face_dir == vfc_pkg::DIR_TOP) && (r_out.mesh_sel == vfc_pkg::MESH_WATER)
             && r_out.last_face))
        else $error("back face record malformed");

    ast_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ((r_done & ~i_head.mask) == '0))
        else $error("done mask outside head mask");

    ast_emit_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !o_pop) |=> (r_done != '0))
        else $error("face emitted without progress");

endmodule

FILE: hdl/voxel_face_cull_mesher_core.sv
`timescale 1ns / 1ps
// The first record of a voxel passes the job queue and then the output register.
// One face record per cycle while the output is not stalled; a voxel holds the back part
// until its visible faces (one to seven) are out, an invisible voxel emits none.
// A four-entry job queue lets input acceptance run ahead of a stalled output.
// Reset clears the queue, the output register valid and all three vertex counters.
module voxel_face_cull_mesher_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  vfc_pkg::t_vox_in   i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vfc_pkg::t_face_out o_out
);

    logic          push;
    logic          full;
    logic          pop;
    logic          head_valid;
    vfc_pkg::t_job job;
    vfc_pkg::t_job head;

    vfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_full     (full),
        .o_push     (push),
        .o_job      (job)
    );

    vfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head)
    );

    vfc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench of voxel_face_cull_mesher_core: drives voxel requests and checks every
// emitted face record against an in-bench prediction of culling and vertex counting.
// Depends on vfc_pkg (payload structs, class, mesh and direction codes) and the core.
module tb_top;

    localparam logic [2:0] BILL_PLANE_0 = 3'd0;
    localparam logic [2:0] BILL_PLANE_1 = 3'd1;

    localparam logic [2:0] SOL = vfc_pkg::CLS_SOLID;
    localparam logic [2:0] LEA = vfc_pkg::CLS_LEAVES;
    localparam logic [2:0] TRA = vfc_pkg::CLS_TRANSP;
    localparam logic [2:0] BIL = vfc_pkg::CLS_BILL;
    localparam logic [2:0] LIQ = vfc_pkg::CLS_LIQUID;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} t_stall_mode;

    class face_ledger;
        vfc_pkg::t_face_out pending_faces[$];
        logic [vfc_pkg::CNT_W-1:0] main_verts;
        logic [vfc_pkg::CNT_W-1:0] water_verts;
        logic [vfc_pkg::CNT_W-1:0] bill_verts;
        int errors;

        function new();
            main_verts = '0;
            water_verts = '0;
            bill_verts = '0;
            errors = 0;
        endfunction

        function bit lets_light(logic [2:0] c);
            case (c)
                vfc_pkg::CLS_LEAVES, vfc_pkg::CLS_TRANSP, vfc_pkg::CLS_BILL: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function vfc_pkg::t_face_out quad(vfc_pkg::t_vox_in v, logic [1:0] mesh,
                                          logic [2:0] dir, logic top, logic back);
            vfc_pkg::t_face_out f;
            f.mesh_sel = mesh;
            f.face_dir = dir;
            f.face_x = v.vox_x;
            f.face_y = v.vox_y;
            f.face_z = v.vox_z;
            f.face_block = v.block_id;
            f.top_flag = top;
            f.back_side = back;
            f.last_face = 1'b0;
            case (mesh)
                vfc_pkg::MESH_WATER: begin
                    f.base_vertex = water_verts;
                    water_verts = water_verts + vfc_pkg::QUAD_VERTS;
                end
                vfc_pkg::MESH_BILL: begin
                    f.base_vertex = bill_verts;
                    bill_verts = bill_verts + vfc_pkg::QUAD_VERTS;
                end
                default: begin
                    f.base_vertex = main_verts;
                    main_verts = main_verts + vfc_pkg::QUAD_VERTS;
                end
            endcase
            return f;
        endfunction

        function void note_voxel(vfc_pkg::t_vox_in v);
            vfc_pkg::t_face_out recs[$];
            vfc_pkg::t_face_out tail;
            logic [2:0] sides[5];
            logic liquid;
            logic side_top;
            logic [1:0] mesh;
            if (v.chunk_start) begin
                main_verts = '0;
                water_verts = '0;
                bill_verts = '0;
            end
            if (v.block_id == '0) return;
            sides = '{v.north_class, v.south_class, v.west_class, v.east_class, v.below_class};
            liquid = (v.self_class == vfc_pkg::CLS_LIQUID);
            if (v.self_class == vfc_pkg::CLS_BILL) begin
                recs = {recs, quad(v, vfc_pkg::MESH_BILL, BILL_PLANE_0, 1'b0, 1'b0)};
                recs = {recs, quad(v, vfc_pkg::MESH_BILL, BILL_PLANE_1, 1'b0, 1'b0)};
            end else begin
                mesh = liquid ? vfc_pkg::MESH_WATER : vfc_pkg::MESH_MAIN;
                side_top = liquid && (v.above_class == vfc_pkg::CLS_TRANSP);
                for (int d = 0; d < 5; d++) begin
                    if (lets_light(sides[d])
                        || (sides[d] == vfc_pkg::CLS_LIQUID && !liquid)) begin
                        recs = {recs, quad(v, mesh, 3'(d),
                                (d == vfc_pkg::DIR_BOTTOM) ? 1'b0 : side_top, 1'b0)};
                    end
                end
                if (liquid) begin
                    if (v.above_class != vfc_pkg::CLS_LIQUID) begin
                        recs = {recs, quad(v, vfc_pkg::MESH_WATER, vfc_pkg::DIR_TOP,
                                           1'b1, 1'b0)};
                        recs = {recs, quad(v, vfc_pkg::MESH_WATER, vfc_pkg::DIR_TOP,
                                           1'b1, 1'b1)};
                    end
                end else if (lets_light(v.above_class)
                             || v.above_class == vfc_pkg::CLS_LIQUID) begin
                    recs = {recs, quad(v, vfc_pkg::MESH_MAIN, vfc_pkg::DIR_TOP, 1'b0, 1'b0)};
                end
            end
            if (recs.size() > 0) begin
                tail = recs.pop_back();
                tail.last_face = 1'b1;
                recs = {recs, tail};
            end
            foreach (recs[i]) pending_faces = {pending_faces, recs[i]};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_face(vfc_pkg::t_face_out got);
            vfc_pkg::t_face_out want;
            if (pending_faces.size() == 0) begin
                $display("%0t: face record expected none got %h", $time, got);
                errors++;
                return;
            end
            want = pending_faces.pop_front();
            compare_field("mesh_sel", 32'(want.mesh_sel), 32'(got.mesh_sel));
            compare_field("face_dir", 32'(want.face_dir), 32'(got.face_dir));
            compare_field("face_x", 32'(want.face_x), 32'(got.face_x));
            compare_field("face_y", 32'(want.face_y), 32'(got.face_y));
            compare_field("face_z", 32'(want.face_z), 32'(got.face_z));
            compare_field("face_block", 32'(want.face_block), 32'(got.face_block));
            compare_field("base_vertex", 32'(want.base_vertex), 32'(got.base_vertex));
            compare_field("top_flag", 32'(want.top_flag), 32'(got.top_flag));
            compare_field("back_side", 32'(want.back_side), 32'(got.back_side));
            compare_field("last_face", 32'(want.last_face), 32'(got.last_face));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    vfc_pkg::t_vox_in i_in;
    logic o_out_valid;
    logic i_out_ready;
    vfc_pkg::t_face_out o_out;

    face_ledger ledger;
    logic [11:0] sweep_pos;

    voxel_face_cull_mesher_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out(o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) ledger.check_face(o_out);
    end

    initial begin
        t_stall_mode mode;
        int span;
        int phase;
        i_out_ready = 1'b0;
        phase = 0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 90);
            repeat (span) begin
                @(negedge i_clk);
                phase++;
                case (mode)
                    STALL_NONE: i_out_ready = 1'b1;
                    STALL_RANDOM: i_out_ready = 1'($urandom_range(0, 1));
                    STALL_PERIODIC: i_out_ready = (phase % 5) > 1;
                    default: i_out_ready = ($urandom_range(0, 9) > 6);
                endcase
            end
        end
    end

    task automatic send_voxel(input vfc_pkg::t_vox_in v);
        i_in_valid = 1'b1;
        i_in = v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        ledger.note_voxel(v);
        @(negedge i_clk);
    endtask

    task automatic idle(input int cycles);
        if (cycles > 0) begin
            i_in_valid = 1'b0;
            i_in = vfc_pkg::t_vox_in'({$urandom, $urandom});
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    function automatic vfc_pkg::t_vox_in make_voxel(logic [3:0] x, logic [3:0] y,
                                                    logic [3:0] z, logic [15:0] id,
                                                    logic [2:0] self_c,
                                                    logic [2:0] n, logic [2:0] s,
                                                    logic [2:0] w, logic [2:0] e,
                                                    logic [2:0] b, logic [2:0] a,
                                                    logic cs);
        return {x, y, z, id, self_c, n, s, w, e, b, a, cs};
    endfunction

    function automatic logic [2:0] pick_class();
        if ($urandom_range(0, 11) == 0) return 3'($urandom_range(5, 7));
        return 3'($urandom_range(0, 4));
    endfunction

    function automatic vfc_pkg::t_vox_in random_voxel();
        vfc_pkg::t_vox_in v;
        v.chunk_start = ($urandom_range(0, 39) == 0);
        if (v.chunk_start) sweep_pos = '0;
        if ($urandom_range(0, 3) != 0) begin
            v.vox_x = sweep_pos[3:0];
            v.vox_z = sweep_pos[7:4];
            v.vox_y = sweep_pos[11:8];
        end else begin
            v.vox_x = 4'($urandom);
            v.vox_y = 4'($urandom);
            v.vox_z = 4'($urandom);
        end
        sweep_pos = sweep_pos + 12'd1;
        v.block_id = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        v.self_class = pick_class();
        v.north_class = pick_class();
        v.south_class = pick_class();
        v.west_class = pick_class();
        v.east_class = pick_class();
        v.below_class = pick_class();
        v.above_class = pick_class();
        return v;
    endfunction

    task automatic run_directed();
        send_voxel(make_voxel(0, 0, 0, 16'd1, SOL, TRA, TRA, TRA, TRA, TRA, TRA, 1'b1));
        send_voxel(make_voxel(15, 15, 15, 16'hFFFF, SOL, SOL, SOL, SOL, SOL, SOL, SOL, 1'b0));
        send_voxel(make_voxel(3, 4, 5, 16'd0, SOL, TRA, TRA, TRA, TRA, TRA, TRA, 1'b1));
        send_voxel(make_voxel(1, 2, 3, 16'h00FF, SOL, LEA, TRA, BIL, LIQ, LEA, LIQ, 1'b0));
        idle(3);
        send_voxel(make_voxel(15, 0, 15, 16'hFF00, BIL, LIQ, SOL, TRA, LEA, BIL, LIQ, 1'b0));
        send_voxel(make_voxel(7, 7, 7, 16'h0101, LIQ, LIQ, LIQ, LIQ, LIQ, LIQ, TRA, 1'b0));
        send_voxel(make_voxel(0, 15, 0, 16'h5555, LIQ, TRA, LEA, BIL, TRA, TRA, TRA, 1'b0));
        send_voxel(make_voxel(8, 9, 10, 16'hAAAA, LIQ, LEA, LEA, LEA, LEA, LEA, SOL, 1'b0));
        send_voxel(make_voxel(2, 2, 2, 16'h1234, LIQ, SOL, SOL, SOL, SOL, SOL, LIQ, 1'b0));
        send_voxel(make_voxel(4, 5, 6, 16'h4321, LEA, LIQ, LIQ, LIQ, LIQ, LIQ, LIQ, 1'b0));
        idle(1);
        send_voxel(make_voxel(9, 9, 9, 16'h0F0F, TRA, 3'd5, 3'd6, 3'd7,
                              3'd5, 3'd6, 3'd7, 1'b0));
        send_voxel(make_voxel(10, 11, 12, 16'hF0F0, 3'd5, BIL, BIL, BIL, BIL, BIL, BIL, 1'b0));
        send_voxel(make_voxel(11, 12, 13, 16'h3C3C, 3'd6, LIQ, SOL, LIQ, SOL, LIQ, LEA, 1'b0));
        send_voxel(make_voxel(12, 13, 14, 16'hC3C3, 3'd7, SOL, SOL, SOL, SOL, SOL, BIL, 1'b0));
        send_voxel(make_voxel(5, 6, 7, 16'h0002, LIQ, 3'd5, 3'd6, 3'd7,
                              3'd7, 3'd5, 3'd6, 1'b0));
        send_voxel(make_voxel(6, 7, 8, 16'h8000, BIL, SOL, SOL, SOL, SOL, SOL, SOL, 1'b1));
        send_voxel(make_voxel(13, 14, 15, 16'd0, LIQ, TRA, TRA, TRA, TRA, TRA, TRA, 1'b0));
        idle(5);
        send_voxel(make_voxel(14, 1, 2, 16'h7FFF, SOL, SOL, SOL, SOL, SOL, LEA, SOL, 1'b0));
        send_voxel(make_voxel(8, 7, 9, 16'h6666, LIQ, BIL, SOL, LEA, SOL, LIQ, BIL, 1'b0));
        send_voxel(make_voxel(1, 14, 1, 16'h9999, TRA, LIQ, TRA, SOL, BIL, SOL, LIQ, 1'b0));
        send_voxel(make_voxel(3, 3, 3, 16'h0003, BIL, BIL, BIL, BIL, BIL, BIL, BIL, 1'b0));
    endtask

    task automatic run_random(input int target);
        int made;
        int burst;
        vfc_pkg::t_vox_in v;
        made = 0;
        while (made < target) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                v = random_voxel();
                send_voxel(v);
                made++;
            end
            idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
    endtask

    initial begin
        ledger = new();
        sweep_pos = '0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        run_directed();
        idle(4);
        run_random(409);
        idle(1);
        while (ledger.pending_faces.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (ledger.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/vfc_pkg.sv
hdl/vfc_front.sv
hdl/vfc_queue.sv
hdl/vfc_back.sv
hdl/voxel_face_cull_mesher_core.sv
tb/tb_top.sv
